/* sv/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants for the line rasterizer
// Command codes, the default coordinate width and the per-pixel control
// group handed from the stepping core to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  // Default coordinate width in bits
  localparam int COORD_BITS_DEFAULT = 12;

  // Command carried in tuser
  typedef enum logic {
    OP_LOAD = 1'b0,   // load endpoints, emit first pixel
    OP_STEP = 1'b1    // emit next pixel of the current line
  } op_t;

  // Control group that goes with one pixel
  typedef struct packed {
    logic valid;      // this transfer produces a pixel
    logic last;       // pixel is the far endpoint
  } pix_ctl_t;

endpackage

`default_nettype wire

/* sv/lr_core.sv */
// ----------------------------------------------------------------------------
// lr_core: Bresenham line state and combinational pixel computation
// Holds the current pixel, error term and line setup. On each accepted
// transfer it computes the pixel to emit and updates the line state.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_core
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire op_t                   op,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  output logic      [COORD_BITS-1:0] pix_x,
  output logic      [COORD_BITS-1:0] pix_y,
  output pix_ctl_t                   pix_ctl
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 3;   // error term width, signed

  // Line state
  logic [C-1:0]         cur_x;
  logic [C-1:0]         cur_y;
  logic [C-1:0]         major_end;
  logic [EW-1:0]        inc_straight;   // 2*|minor|
  logic [EW-1:0]        inc_diag;       // 2*|minor| - 2*|major|
  logic signed [EW-1:0] error_term;
  logic                 minor_step_negative;
  logic                 y_is_major;
  logic                 line_active;

  // Line setup from the endpoints
  logic [C-1:0]  adx, ady, maj_d, min_d;
  logic [C-1:0]  xa, ya, xb, yb;
  logic          ymaj0, swap0, minor_neg0, active0;
  logic [EW-1:0] err0, inc_str0, inc_diag0;

  always_comb begin
    adx        = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
    ady        = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);
    ymaj0      = ady > adx;
    swap0      = ymaj0 ? (y_start > y_end) : (x_start > x_end);
    xa         = swap0 ? x_end   : x_start;
    ya         = swap0 ? y_end   : y_start;
    xb         = swap0 ? x_start : x_end;
    yb         = swap0 ? y_start : y_end;
    minor_neg0 = ymaj0 ? (xb < xa) : (yb < ya);
    maj_d      = ymaj0 ? ady : adx;
    min_d      = ymaj0 ? adx : ady;
    inc_str0   = {2'b00, min_d, 1'b0};
    inc_diag0  = inc_str0 - {2'b00, maj_d, 1'b0};
    err0       = inc_str0 - {3'b000, maj_d};
    active0    = maj_d != '0;
  end

  // One step along the current line
  logic                 move_minor;
  logic [C-1:0]         maj_cur, mnr_cur, maj_nxt, mnr_nxt;
  logic [C-1:0]         step_x, step_y;
  logic signed [EW-1:0] err_step;
  logic                 step_done;

  always_comb begin
    move_minor = !error_term[EW-1];
    maj_cur    = y_is_major ? cur_y : cur_x;
    mnr_cur    = y_is_major ? cur_x : cur_y;
    maj_nxt    = maj_cur + C'(1);
    if (!move_minor) begin
      mnr_nxt = mnr_cur;
    end else if (minor_step_negative) begin
      mnr_nxt = mnr_cur - C'(1);
    end else begin
      mnr_nxt = mnr_cur + C'(1);
    end
    step_x    = y_is_major ? mnr_nxt : maj_nxt;
    step_y    = y_is_major ? maj_nxt : mnr_nxt;
    err_step  = error_term + $signed(move_minor ? inc_diag : inc_straight);
    step_done = maj_nxt == major_end;
  end

  // Pixel emitted for this transfer
  always_comb begin
    if (op == OP_LOAD) begin
      pix_x         = xa;
      pix_y         = ya;
      pix_ctl.valid = 1'b1;
      pix_ctl.last  = !active0;
    end else begin
      pix_x         = step_x;
      pix_y         = step_y;
      pix_ctl.valid = line_active;
      pix_ctl.last  = step_done;
    end
  end

  // Line state update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (fire) begin
      if (op == OP_LOAD) begin
        line_active <= active0;
      end else if (line_active) begin
        line_active <= !step_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (op == OP_LOAD) begin
        cur_x               <= xa;
        cur_y               <= ya;
        major_end           <= ymaj0 ? yb : xb;
        inc_straight        <= inc_str0;
        inc_diag            <= inc_diag0;
        error_term          <= $signed(err0);
        minor_step_negative <= minor_neg0;
        y_is_major          <= ymaj0;
      end else if (line_active) begin
        cur_x      <= step_x;
        cur_y      <= step_y;
        error_term <= err_step;
      end
    end
  end

  // Checks
  a_load_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && op == OP_LOAD) |-> pix_ctl.valid)
    else $error("load transfer produced no pixel");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && op == OP_STEP && !line_active) |-> !pix_ctl.valid)
    else $error("step with no line produced a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (fire && pix_ctl.valid && pix_ctl.last) |=> !line_active)
    else $error("line still active after its last pixel");

  a_error_sign_bound: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (error_term[EW-1] == error_term[EW-2]))
    else $error("error term out of range");

endmodule

`default_nettype wire

/* sv/lr_out.sv */
// ----------------------------------------------------------------------------
// lr_out: pixel result register
// Captures a pixel on an input transfer and holds it until the downstream
// side takes it; input is accepted whenever the register is free or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_out
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int OUT_BITS   = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire logic [COORD_BITS-1:0] pix_x,
  input  wire logic [COORD_BITS-1:0] pix_y,
  input  wire pix_ctl_t              pix_ctl,
  output logic                       in_ready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_BITS-1:0]        m_tdata,   // point_x, point_y
  output logic                       m_tlast    // last_point
);

  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_last;

  // Free to take a transfer when empty or being drained this cycle
  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && pix_ctl.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pix_ctl.valid) begin
      out_x    <= pix_x;
      out_y    <= pix_y;
      out_last <= pix_ctl.last;
    end
  end

  assign m_tdata = OUT_BITS'({out_y, out_x});
  assign m_tlast = out_last;

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !fire)
    else $error("input taken while result stalled");

  a_pixel_lands: assert property (@(posedge clk) disable iff (rst)
    (fire && pix_ctl.valid) |=> m_tvalid)
    else $error("pixel not registered");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !(fire && pix_ctl.valid)) |=> !m_tvalid)
    else $error("result repeated after transfer");

endmodule

`default_nettype wire

/* sv/line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_top: Bresenham line stepper
// A pixel appears on the master side in the cycle after its transfer.
// Throughput: one item per cycle while m_tready is high; one add and
// compare on the error term per step; the result register frees when taken.
// Reset: synchronous, clears the line-active flag and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_top
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int IN_BITS    = ((4 * COORD_BITS + 7) / 8) * 8,
  parameter int OUT_BITS   = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_BITS-1:0]  s_tdata,   // x_start, y_start, x_end, y_end
  input  wire logic [0:0]          s_tuser,   // op
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_BITS-1:0]      m_tdata,   // point_x, point_y
  output logic                     m_tlast    // last_point
);

  localparam int C = COORD_BITS;

  logic          fire;
  op_t           op;
  logic [C-1:0]  x_start, y_start, x_end, y_end;
  logic [C-1:0]  pix_x, pix_y;
  pix_ctl_t      pix_ctl;

  // Unpack the slave transfer
  assign fire    = s_tvalid && s_tready;
  assign op      = op_t'(s_tuser[0]);
  assign x_start = s_tdata[C-1:0];
  assign y_start = s_tdata[2*C-1:C];
  assign x_end   = s_tdata[3*C-1:2*C];
  assign y_end   = s_tdata[4*C-1:3*C];

  lr_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (op),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .pix_x   (pix_x),
    .pix_y   (pix_y),
    .pix_ctl (pix_ctl)
  );

  lr_out #(
    .COORD_BITS(COORD_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .pix_ctl  (pix_ctl),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
